// ===== hw/rtl/shcw_pkg.sv =====
package shcw_pkg;

  localparam int unsigned PhaseBits   = 16;
  localparam int unsigned SineEntries = 1024;
  localparam int unsigned StepBits    = 32;
  localparam int unsigned OffsetBits  = 16;
  localparam int unsigned WaveBits    = 32;
  localparam int unsigned ColorBits   = 24;
  localparam int unsigned ChanBits    = 8;
  localparam int unsigned Chans       = 3;
  localparam int unsigned FactorBits  = 16;
  localparam int unsigned ProdBits    = FactorBits + ChanBits;
  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned CfgIdxBits  = 2;

  // Long division of {time_step, PhaseBits zeros} by the wave period, one bit per cell.
  localparam int unsigned DivSteps = StepBits + PhaseBits;

  // Sine table split into banks of at most 256 entries.
  localparam int unsigned AddrBits  = $clog2(SineEntries);
  localparam int unsigned BankBits  = (AddrBits < 8) ? AddrBits : 8;
  localparam int unsigned BankDepth = 2 ** BankBits;
  localparam int unsigned Banks     = SineEntries / BankDepth;
  localparam int unsigned SelBits   = (Banks > 1) ? $clog2(Banks) : 1;

  localparam longint PiQ30  = 64'sd3373259426;
  localparam longint OneQ30 = 64'sd1073741824;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgStartColor = 2'd0,
    CfgStopColor  = 2'd1,
    CfgWavePeriod = 2'd2
  } shcw_cfg_e;

  typedef logic [Chans-1:0][ChanBits-1:0] shcw_rgb_t;

  typedef struct packed {
    logic [WaveBits-1:0]   rem;
    logic [StepBits-1:0]   num;
    logic [PhaseBits-1:0]  quo;
    logic [OffsetBits-1:0] offset;
  } shcw_div_t;

  typedef logic [BankDepth-1:0][FactorBits-1:0] shcw_bank_t;

  // Quarter-wave Taylor sine in Q30, terms to x^13.
  function automatic longint quadrant_sine(longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >>> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 156;
    sum  = sum + term;
    if (sum < 0) sum = 0;
    if (sum > OneQ30) sum = OneQ30;
    return sum;
  endfunction

  // One bank of (1 + sin) / 2 in unsigned Q0.16, evaluated at elaboration.
  function automatic shcw_bank_t build_bank(int unsigned bank);
    shcw_bank_t rom;
    longint     k;
    longint     x;
    longint     s;
    longint     f;
    longint     q;
    logic       neg;
    for (int unsigned i = 0; i < BankDepth; i++) begin
      k   = longint'(bank) * longint'(BankDepth) + longint'(i);
      x   = (2 * PiQ30 * k) / SineEntries;
      neg = 1'b0;
      if (x > PiQ30) begin
        x   = x - PiQ30;
        neg = 1'b1;
      end
      if (x > PiQ30 / 2) x = PiQ30 - x;
      s = quadrant_sine(x);
      f = neg ? (OneQ30 - s) : (OneQ30 + s);
      q = (f + 16384) >>> 15;
      if (q > 65535) q = 65535;
      rom[i] = q[FactorBits-1:0];
    end
    return rom;
  endfunction

endpackage

// ===== hw/rtl/shcw_div_cell.sv =====
module shcw_div_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [shcw_pkg::WaveBits-1:0] wave_period_i,
  input  logic                       valid_i,
  input  shcw_pkg::shcw_div_t        data_i,
  output logic                       valid_o,
  output shcw_pkg::shcw_div_t        data_o
);
  import shcw_pkg::*;

  logic              valid_q;
  shcw_div_t         data_q;
  shcw_div_t         data_d;
  logic [WaveBits:0] trial;
  logic [WaveBits:0] diff;
  logic              ge;

  // Bring down the next numerator bit and try one subtract.
  always_comb begin
    trial         = {data_i.rem, data_i.num[StepBits-1]};
    diff          = trial - {1'b0, wave_period_i};
    ge            = (trial >= {1'b0, wave_period_i});
    data_d        = data_i;
    data_d.rem    = ge ? diff[WaveBits-1:0] : trial[WaveBits-1:0];
    data_d.num    = {data_i.num[StepBits-2:0], 1'b0};
    data_d.quo    = {data_i.quo[PhaseBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/shcw_sine_rom.sv =====
module shcw_sine_rom (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [shcw_pkg::AddrBits-1:0]  index_i,
  output logic                           valid_o,
  output logic [shcw_pkg::FactorBits-1:0] factor_o
);
  import shcw_pkg::*;

  logic [FactorBits-1:0] bank_q [Banks];
  logic [SelBits-1:0]    sel_q;
  logic                  read_valid_q;
  logic [FactorBits-1:0] factor_q;
  logic                  factor_valid_q;

  // Read every bank at the low address bits; pick the bank one stage later.
  for (genvar b = 0; b < Banks; b++) begin : g_bank
    localparam shcw_bank_t BankRom = build_bank(b);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        bank_q[b] <= BankRom[index_i[BankBits-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_q    <= SelBits'(index_i >> BankBits);
      factor_q <= bank_q[sel_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_valid_q   <= 1'b0;
      factor_valid_q <= 1'b0;
    end else if (en_i) begin
      read_valid_q   <= valid_i;
      factor_valid_q <= read_valid_q;
    end
  end

  assign valid_o  = factor_valid_q;
  assign factor_o = factor_q;

endmodule

// ===== hw/rtl/shcw_blend.sv =====
module shcw_blend (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [shcw_pkg::FactorBits-1:0] factor_i,
  input  shcw_pkg::shcw_rgb_t             start_color_i,
  input  shcw_pkg::shcw_rgb_t             stop_color_i,
  output logic                            valid_o,
  output shcw_pkg::shcw_rgb_t             color_o
);
  import shcw_pkg::*;

  logic                valid_q;
  shcw_rgb_t           base_q;
  logic [Chans-1:0]    rise_q;
  logic [ProdBits-1:0] prod_q [Chans];
  logic [ChanBits-1:0] span    [Chans];
  logic [ProdBits:0]   prod_up [Chans];

  // One lane per channel: span, product, then step from the start value.
  always_comb begin
    for (int c = 0; c < Chans; c++) begin
      span[c] = (stop_color_i[c] >= start_color_i[c]) ?
                (stop_color_i[c] - start_color_i[c]) :
                (start_color_i[c] - stop_color_i[c]);
      // Round the magnitude up on a falling channel so the floor heads down.
      prod_up[c] = {1'b0, prod_q[c]} + (ProdBits + 1)'((2 ** FactorBits) - 1);
      if (rise_q[c]) begin
        color_o[c] = base_q[c] + prod_q[c][FactorBits +: ChanBits];
      end else begin
        color_o[c] = base_q[c] - prod_up[c][FactorBits +: ChanBits];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q <= start_color_i;
      for (int c = 0; c < Chans; c++) begin
        rise_q[c] <= (stop_color_i[c] >= start_color_i[c]);
        prod_q[c] <= ProdBits'(factor_i) * ProdBits'(span[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;

endmodule

// ===== hw/rtl/shimmer_color_wave.sv =====
// Shimmer color wave: blends two RGB colors by a sine of the animation step.
//
// Input channel: in_valid_i / in_stall_o carry time_step_i and phase_offset_i.
// A transaction completes at a rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry red_o, green_o, blue_o,
// exactly one result transaction per input transaction, in order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 start color, 1 stop color, 2 wave period); write only while idle.
//
// Throughput: one transaction per cycle while in_stall_o is low. From input to
// output valid a transaction passes 48 divider cells (one quotient bit each,
// for the step phase (time_step mod period) / period), two sine table stages,
// one multiply stage and the output register.
// Reset clears all valid flags and loads start 0x000000, stop 0xFFFFFF,
// period 64. When the receiver stalls, the output holds and one more result
// lands in a skid register; only when that is full does in_stall_o rise, so
// the chain never drops or repeats a transaction.
module shimmer_color_wave (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [shcw_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [shcw_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [shcw_pkg::StepBits-1:0]     time_step_i,
  input  logic [shcw_pkg::OffsetBits-1:0]   phase_offset_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [shcw_pkg::ChanBits-1:0]     red_o,
  output logic [shcw_pkg::ChanBits-1:0]     green_o,
  output logic [shcw_pkg::ChanBits-1:0]     blue_o
);
  import shcw_pkg::*;

  // Configuration registers.
  shcw_rgb_t           start_color_q;
  shcw_rgb_t           stop_color_q;
  logic [WaveBits-1:0] wave_period_q;

  // Pipeline advance: the whole chain moves unless the skid slot is taken.
  logic                pipe_en;

  // Divider chain links; entry 0 is the input side.
  logic                div_valid [DivSteps+1];
  shcw_div_t           div_data  [DivSteps+1];

  logic [PhaseBits-1:0] step_phase;
  logic [PhaseBits-1:0] off_phase;
  logic [PhaseBits-1:0] phase;

  logic                  factor_valid;
  logic [FactorBits-1:0] factor;
  logic                  blend_valid;
  shcw_rgb_t             blend_color;

  // Output register and skid slot.
  logic      out_valid_q;
  shcw_rgb_t out_color_q;
  logic      skid_full_q;
  shcw_rgb_t skid_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_color_q <= shcw_rgb_t'(24'h000000);
      stop_color_q  <= shcw_rgb_t'(24'hFFFFFF);
      wave_period_q <= WaveBits'(64);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgStartColor: start_color_q <= shcw_rgb_t'(cfg_data_i[ColorBits-1:0]);
        CfgStopColor:  stop_color_q  <= shcw_rgb_t'(cfg_data_i[ColorBits-1:0]);
        CfgWavePeriod: wave_period_q <= cfg_data_i[WaveBits-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  assign pipe_en    = !skid_full_q;
  assign in_stall_o = skid_full_q;

  // Feed the chain: remainder starts at zero, the step is the numerator.
  assign div_valid[0]       = in_valid_i && !in_stall_o;
  assign div_data[0].rem    = '0;
  assign div_data[0].num    = time_step_i;
  assign div_data[0].quo    = '0;
  assign div_data[0].offset = phase_offset_i;

  for (genvar i = 0; i < DivSteps; i++) begin : g_cell
    shcw_div_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (pipe_en),
      .wave_period_i (wave_period_q),
      .valid_i       (div_valid[i]),
      .data_i        (div_data[i]),
      .valid_o       (div_valid[i+1]),
      .data_o        (div_data[i+1])
    );
  end

  // The low quotient bits of (step << PhaseBits) / period are the step phase.
  // A zero period leaves only the offset.
  assign step_phase = (wave_period_q == '0) ? '0 : div_data[DivSteps].quo;

  if (PhaseBits >= OffsetBits) begin : g_off_up
    assign off_phase = PhaseBits'(div_data[DivSteps].offset) << (PhaseBits - OffsetBits);
  end else begin : g_off_down
    assign off_phase = PhaseBits'(div_data[DivSteps].offset >> (OffsetBits - PhaseBits));
  end

  // Wraps modulo one turn.
  assign phase = step_phase + off_phase;

  shcw_sine_rom u_sine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (div_valid[DivSteps]),
    .index_i  (phase[PhaseBits-1 -: AddrBits]),
    .valid_o  (factor_valid),
    .factor_o (factor)
  );

  shcw_blend u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (pipe_en),
    .valid_i       (factor_valid),
    .factor_i      (factor),
    .start_color_i (start_color_q),
    .stop_color_i  (stop_color_q),
    .valid_o       (blend_valid),
    .color_o       (blend_color)
  );

  // Output side: hold while stalled, park one result in the skid slot, drain
  // the slot first once the receiver takes again.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (out_valid_q && out_stall_i) begin
      if (pipe_en && blend_valid) begin
        skid_full_q <= 1'b1;
      end
    end else if (skid_full_q) begin
      out_valid_q <= 1'b1;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= blend_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_stall_i) begin
      if (pipe_en && blend_valid) begin
        skid_color_q <= blend_color;
      end
    end else if (skid_full_q) begin
      out_color_q <= skid_color_q;
    end else begin
      out_color_q <= blend_color;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = out_color_q[2];
  assign green_o     = out_color_q[1];
  assign blue_o      = out_color_q[0];

  // A parked result always sits behind a shown one.
  a_skid_behind_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni) skid_full_q |-> out_valid_q
  ) else $error("skid slot full with no output shown");

  // The skid slot fills only when the shown result was stalled.
  a_skid_fill_cause: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(skid_full_q) |-> $past(out_valid_o && out_stall_i)
  ) else $error("skid slot filled without a stalled output");

  // A parked result drains as soon as the receiver takes.
  a_skid_drain: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (skid_full_q && !out_stall_i) |=> (!skid_full_q && out_valid_q)
  ) else $error("skid slot did not drain");

endmodule
